### rtl/msa_pkg.sv
package msa_pkg;

	localparam int CAPACITY_DEF = 1024;

	localparam int KIND_W = 2;
	localparam int SLOT_W = 10;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 11;

	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 40;

	typedef enum logic [KIND_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_MARK  = 2'd1,
		OP_SWEEP = 2'd2
	} kind_t;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RMW   = 4'b0010,
		S_SWEEP = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

endpackage

### rtl/msa_ram.sv
module msa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/mark_sweep_slot_allocator.sv
// mark-and-sweep slot allocator
//
// input channel s_*: one beat per operation; s_tdata = {slot[11:2], kind[1:0]}
//   kind 0 allocate, 1 mark slot to keep, 2 sweep unmarked slots, 3 no-op
// output channel m_*: exactly one result beat per operation;
//   m_tdata = {high_water[33:23], live_count[22:12], status[11:10], granted_slot[9:0]}
//
// all per-slot state (free-list link, free flag, keep mark) lives in one
// single-port-read ram; allocate from the free list and mark read an entry, modify
// it and write it back; allocate from an empty list writes a fresh entry, while
// full allocate, out-of-range mark and no-op leave the ram alone; sweep reads
// and writes back each slot below high_water, one slot per cycle through the
// ram read/write pipe
// one operation is in flight at a time; s_tready is high only when idle, so
// the next beat is taken only after the previous result has been registered
// the result register holds while m_tready is low; a finished operation then
// waits until the register frees before the next beat is taken
// reset clears the counters and the free-list head; no clearing pass is run,
// a slot's keep mark is written when the slot is first handed out
module mark_sweep_slot_allocator #(
	parameter int CAPACITY = msa_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [msa_pkg::S_DATA_W-1:0] s_tdata,   // kind, slot
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [msa_pkg::M_DATA_W-1:0] m_tdata  // granted_slot, status, live_count, high_water
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic          keep;
		logic          free;
		logic [CW-1:0] link;
	} entry_t;

	msa_pkg::state_t state_q;
	logic [CW-1:0] head_q;
	logic [CW-1:0] limit_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] addr_q;
	logic          op_mark_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] res_granted_q;
	logic [msa_pkg::STATUS_W-1:0] res_status_q;
	logic          m_tvalid_q;
	logic [msa_pkg::M_DATA_W-1:0] m_tdata_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_rdata;

	msa_pkg::kind_t kind;
	logic          accept;
	logic [31:0]   slot_w;
	logic          slot_ok;
	logic          list_nonempty;
	logic          full;
	logic [CW-1:0] idx_nxt;
	logic          sweep_more;
	logic          sweep_link;
	logic          out_free;
	logic [31:0]   granted_w;
	logic [31:0]   live_w;
	logic [31:0]   high_w;

	assign kind          = msa_pkg::kind_t'(s_tdata[1:0]);
	assign accept        = s_tvalid && s_tready;
	assign s_tready      = (state_q == msa_pkg::S_IDLE);
	assign slot_w        = 32'(s_tdata[11:2]);
	assign slot_ok       = slot_w < 32'(limit_q);
	assign list_nonempty = count_q < limit_q;
	assign full          = limit_q >= CW'(CAPACITY);
	assign idx_nxt       = CW'(idx_q) + CW'(1);
	assign sweep_more    = idx_nxt < limit_q;
	assign sweep_link    = !ram_rdata.keep && !ram_rdata.free;
	assign out_free      = !m_tvalid_q || m_tready;

	assign granted_w = 32'(res_granted_q);
	assign live_w    = 32'(count_q);
	assign high_w    = 32'(limit_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			msa_pkg::S_IDLE: begin
				if (accept) begin
					case (kind)
						msa_pkg::OP_ALLOC: begin
							if (list_nonempty) begin
								ram_re    = 1'b1;
								ram_raddr = head_q[AW-1:0];
							end else if (!full) begin
								ram_we    = 1'b1;
								ram_waddr = limit_q[AW-1:0];
							end
						end
						msa_pkg::OP_MARK: begin
							if (slot_ok) begin
								ram_re    = 1'b1;
								ram_raddr = slot_w[AW-1:0];
							end
						end
						msa_pkg::OP_SWEEP: begin
							if (limit_q != '0) begin
								ram_re = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			msa_pkg::S_RMW: begin
				ram_we    = 1'b1;
				ram_waddr = addr_q;
				ram_wdata = ram_rdata;
				if (op_mark_q) begin
					ram_wdata.keep = 1'b1;
				end else begin
					ram_wdata.free = 1'b0;
				end
			end
			msa_pkg::S_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
				ram_wdata.keep = 1'b0;
				if (sweep_link) begin
					ram_wdata.free = 1'b1;
					ram_wdata.link = head_q;
				end
				if (sweep_more) begin
					ram_re    = 1'b1;
					ram_raddr = idx_nxt[AW-1:0];
				end
			end
			msa_pkg::S_EMIT: ;
			default: ;
		endcase
	end

	msa_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CAPACITY)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= msa_pkg::S_IDLE;
			head_q        <= '0;
			limit_q       <= '0;
			count_q       <= '0;
			addr_q        <= '0;
			op_mark_q     <= 1'b0;
			idx_q         <= '0;
			res_granted_q <= '0;
			res_status_q  <= msa_pkg::ST_OK;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != msa_pkg::S_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				msa_pkg::S_IDLE: begin
					if (accept) begin
						res_granted_q <= '0;
						res_status_q  <= msa_pkg::ST_OK;
						state_q       <= msa_pkg::S_EMIT;
						case (kind)
							msa_pkg::OP_ALLOC: begin
								if (list_nonempty) begin
									addr_q    <= head_q[AW-1:0];
									op_mark_q <= 1'b0;
									state_q   <= msa_pkg::S_RMW;
								end else if (full) begin
									res_status_q <= msa_pkg::ST_FULL;
								end else begin
									res_granted_q <= limit_q[AW-1:0];
									limit_q       <= limit_q + CW'(1);
									head_q        <= limit_q + CW'(1);
									count_q       <= count_q + CW'(1);
								end
							end
							msa_pkg::OP_MARK: begin
								if (slot_ok) begin
									addr_q    <= slot_w[AW-1:0];
									op_mark_q <= 1'b1;
									state_q   <= msa_pkg::S_RMW;
								end else begin
									res_status_q <= msa_pkg::ST_RANGE;
								end
							end
							msa_pkg::OP_SWEEP: begin
								if (limit_q != '0) begin
									idx_q   <= '0;
									state_q <= msa_pkg::S_SWEEP;
								end
							end
							default: ;
						endcase
					end
				end
				msa_pkg::S_RMW: begin
					if (!op_mark_q) begin
						head_q        <= ram_rdata.link;
						count_q       <= count_q + CW'(1);
						res_granted_q <= addr_q;
					end
					state_q <= msa_pkg::S_EMIT;
				end
				msa_pkg::S_SWEEP: begin
					if (sweep_link) begin
						head_q <= CW'(idx_q);
						if (count_q != '0) begin
							count_q <= count_q - CW'(1);
						end
					end
					if (sweep_more) begin
						idx_q <= idx_nxt[AW-1:0];
					end else begin
						state_q <= msa_pkg::S_EMIT;
					end
				end
				msa_pkg::S_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'd0, high_w[10:0], live_w[10:0], res_status_q,
							granted_w[9:0]};
						state_q    <= msa_pkg::S_IDLE;
					end
				end
				default: state_q <= msa_pkg::S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_count_le_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= limit_q)
		else $error("live count above high-water mark");

	a_limit_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		limit_q <= CW'(CAPACITY))
		else $error("high-water mark above capacity");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == msa_pkg::S_EMIT))
		else $error("result beat raised outside emit");

	a_sweep_walks_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msa_pkg::S_SWEEP) |-> (CW'(idx_q) < limit_q))
		else $error("sweep index beyond high-water mark");

endmodule

### dv/mark_sweep_slot_allocator_test.sv
`timescale 1ns / 1ps

module mark_sweep_slot_allocator_test;

	localparam int CAP = msa_pkg::CAPACITY_DEF;
	localparam logic [msa_pkg::KIND_W-1:0] OP_NONE = 2'd3;
	localparam int QUIET_LIMIT = 8000;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE_CYCLES = CAP + 16;
	localparam int RANDOM_OPS = 100;

	typedef logic [msa_pkg::SLOT_W-1:0]  slot_t;
	typedef logic [msa_pkg::COUNT_W-1:0] count_t;
	typedef logic [msa_pkg::KIND_W-1:0]  kind_code_t;

	typedef struct packed {
		slot_t                        granted;
		logic [msa_pkg::STATUS_W-1:0] status;
		count_t                       live;
		count_t                       high;
	} slot_result_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_COMB
	} rx_mode_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [msa_pkg::S_DATA_W-1:0] s_tdata = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [msa_pkg::M_DATA_W-1:0] m_tdata;

	// shadow of the allocator state
	count_t pool_link [CAP];
	bit     pool_free [CAP];
	bit     pool_keep [CAP];
	int     pool_head;
	int     pool_high;
	int     pool_live;

	slot_result_t pending_results[$];
	int           fail_count;
	int           burst_left;
	int           quiet_cycles;
	bit           hold_req;
	int           hold_left;
	rx_mode_t     rx_mode;
	int           rx_mode_left;
	int           rx_phase;

	mark_sweep_slot_allocator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic apply_to_pool(kind_code_t kind, slot_t slot);
		slot_result_t r;
		int s;
		r = '0;
		r.status = msa_pkg::ST_OK;
		if (kind == msa_pkg::OP_ALLOC) begin
			if (pool_live < pool_high) begin
				s = pool_head;
				pool_head = int'(pool_link[s]);
				pool_free[s] = 1'b0;
				pool_live++;
				r.granted = slot_t'(s);
			end else if (pool_high >= CAP) begin
				r.status = msa_pkg::ST_FULL;
			end else begin
				s = pool_high;
				pool_free[s] = 1'b0;
				pool_high++;
				pool_head = pool_high;
				pool_live++;
				r.granted = slot_t'(s);
			end
		end else if (kind == msa_pkg::OP_MARK) begin
			if (int'(slot) < pool_high)
				pool_keep[slot] = 1'b1;
			else
				r.status = msa_pkg::ST_RANGE;
		end else if (kind == msa_pkg::OP_SWEEP) begin
			for (int i = 0; i < pool_high; i++) begin
				if (!pool_keep[i] && !pool_free[i]) begin
					pool_link[i] = count_t'(pool_head);
					pool_head = i;
					pool_free[i] = 1'b1;
					if (pool_live > 0)
						pool_live--;
				end
			end
			for (int i = 0; i < CAP; i++)
				pool_keep[i] = 1'b0;
		end
		r.live = count_t'(pool_live);
		r.high = count_t'(pool_high);
		pending_results.push_back(r);
	endtask

	task automatic send_op(kind_code_t kind, slot_t slot);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 6);
		end
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(msa_pkg::S_DATA_W - msa_pkg::SLOT_W - msa_pkg::KIND_W){1'b0}}, slot, kind};
		do @(posedge clk); while (!s_tready);
		apply_to_pool(kind, slot);
		burst_left--;
	endtask

	task automatic stop_offering();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic send_random_op();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			send_op(msa_pkg::OP_ALLOC, slot_t'($urandom_range(0, CAP - 1)));
		else if (pick < 80 && pool_high > 0)
			send_op(msa_pkg::OP_MARK, slot_t'($urandom_range(0, pool_high - 1)));
		else if (pick < 88)
			send_op(msa_pkg::OP_MARK, slot_t'($urandom_range(0, CAP - 1)));
		else if (pick < 93)
			send_op(OP_NONE, slot_t'($urandom_range(0, CAP - 1)));
		else
			send_op(msa_pkg::OP_SWEEP, slot_t'($urandom_range(0, CAP - 1)));
	endtask

	task automatic test_directed();
		send_op(msa_pkg::OP_SWEEP, 10'd0);
		send_op(msa_pkg::OP_MARK, 10'd0);
		send_op(OP_NONE, 10'h3ff);
		send_op(msa_pkg::OP_ALLOC, 10'h3ff);
		send_op(msa_pkg::OP_ALLOC, 10'd0);
		send_op(msa_pkg::OP_ALLOC, 10'd0);
		send_op(msa_pkg::OP_ALLOC, 10'd0);
		send_op(msa_pkg::OP_MARK, 10'd1);
		send_op(msa_pkg::OP_MARK, 10'd3);
		send_op(msa_pkg::OP_MARK, 10'd4);
		send_op(msa_pkg::OP_MARK, 10'h3ff);
		send_op(msa_pkg::OP_SWEEP, 10'h3ff);
		send_op(msa_pkg::OP_MARK, 10'd0);
		send_op(msa_pkg::OP_SWEEP, 10'd0);
		send_op(msa_pkg::OP_ALLOC, 10'd0);
		send_op(msa_pkg::OP_ALLOC, 10'd0);
		send_op(msa_pkg::OP_ALLOC, 10'd0);
		send_op(msa_pkg::OP_ALLOC, 10'd0);
		send_op(msa_pkg::OP_MARK, 10'd2);
		send_op(msa_pkg::OP_MARK, 10'd2);
		send_op(msa_pkg::OP_SWEEP, 10'd0);
		send_op(OP_NONE, 10'd0);
		stop_offering();
	endtask

	task automatic test_random_mix();
		repeat (RANDOM_OPS) send_random_op();
		stop_offering();
	endtask

	task automatic test_output_stall();
		hold_req = 1'b1;
		repeat (12) send_random_op();
		stop_offering();
	endtask

	task automatic test_full_pool();
		while (pool_live < CAP)
			send_op(msa_pkg::OP_ALLOC, slot_t'($urandom_range(0, CAP - 1)));
		repeat (3) send_op(msa_pkg::OP_ALLOC, slot_t'($urandom_range(0, CAP - 1)));
		send_op(msa_pkg::OP_MARK, 10'h3ff);
		send_op(msa_pkg::OP_MARK, 10'h200);
		send_op(msa_pkg::OP_MARK, 10'd0);
		repeat (8) send_op(msa_pkg::OP_MARK, slot_t'($urandom_range(0, CAP - 1)));
		send_op(OP_NONE, 10'h155);
		send_op(msa_pkg::OP_SWEEP, 10'h2aa);
		repeat (6) send_op(msa_pkg::OP_ALLOC, 10'd0);
		send_op(msa_pkg::OP_MARK, 10'd100);
		send_op(msa_pkg::OP_MARK, 10'h3ff);
		send_op(msa_pkg::OP_SWEEP, 10'd0);
		repeat (4) send_op(msa_pkg::OP_ALLOC, 10'd0);
		stop_offering();
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (rx_mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_mode_left = $urandom_range(20, 200);
		end else begin
			rx_mode_left--;
		end
		rx_phase = (rx_phase + 1) % 3;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN: m_tready <= 1'b1;
				RX_COIN: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= (rx_phase == 0);
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		slot_result_t want;
		slot_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.granted = m_tdata[9:0];
			got.status = m_tdata[11:10];
			got.live = m_tdata[22:12];
			got.high = m_tdata[33:23];
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected beat granted=%0d status=%0d live=%0d high=%0d",
						$time, got.granted, got.status, got.live, got.high);
			end else begin
				want = pending_results.pop_front();
				if (got != want) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: mismatch expected granted=%0d status=%0d live=%0d high=%0d",
							$time, want.granted, want.status, want.live, want.high);
						$display("%0t:          got granted=%0d status=%0d live=%0d high=%0d",
							$time, got.granted, got.status, got.live, got.high);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("mark_sweep_slot_allocator verification failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < CAP; i++) begin
			pool_link[i] = '0;
			pool_free[i] = 1'b0;
			pool_keep[i] = 1'b0;
		end
		pool_head = 0;
		pool_high = 0;
		pool_live = 0;
		fail_count = 0;
		burst_left = 0;
		quiet_cycles = 0;
		hold_req = 1'b0;
		hold_left = 0;
		rx_mode = RX_OPEN;
		rx_mode_left = 0;
		rx_phase = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_mix();
		test_output_stall();
		test_full_pool();

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("mark_sweep_slot_allocator verification clean");
		else
			$display("mark_sweep_slot_allocator verification failed");
		$finish;
	end

endmodule
